### rtl/btff_pkg.sv
package btff_pkg;

    localparam int POOL_BYTES  = 1024;
    localparam int TAG_BYTES   = 8;
    localparam int MIN_PAYLOAD = 16;

    localparam int DEPTH  = POOL_BYTES / 2;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OFF_W  = $clog2(POOL_BYTES);
    localparam int POS_W  = OFF_W + 1;
    localparam int LINK_W = OFF_W + 1;

    localparam logic [OFF_W-1:0]  INIT_SIZE   = OFF_W'(POOL_BYTES - 2 * TAG_BYTES);
    localparam logic [OFF_W-1:0]  END_TAG_POS = OFF_W'(POOL_BYTES - TAG_BYTES);
    localparam logic [OFF_W-1:0]  TAG1_O      = OFF_W'(TAG_BYTES);
    localparam logic [OFF_W-1:0]  TAG2_O      = OFF_W'(2 * TAG_BYTES);
    localparam logic [POS_W-1:0]  TAG1_P      = POS_W'(TAG_BYTES);
    localparam logic [POS_W-1:0]  TAG2_P      = POS_W'(2 * TAG_BYTES);
    localparam logic [POS_W-1:0]  MIN_N       = POS_W'(MIN_PAYLOAD);
    localparam logic [POS_W-1:0]  SPLIT_EXTRA = POS_W'(MIN_PAYLOAD + 2 * TAG_BYTES);
    localparam logic [POS_W-1:0]  WALK_LIMIT  = POS_W'(POOL_BYTES - 2 * TAG_BYTES);
    localparam logic [POS_W-1:0]  RIGHT_LIMIT = POS_W'(POOL_BYTES - TAG_BYTES);
    localparam logic [LINK_W-1:0] LINK_NONE   = {1'b1, {OFF_W{1'b0}}};

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP, OP_INIT0, OP_INIT1, OP_ACCEPT, OP_FIT_STEP,
        OP_SPL_W0, OP_SPL_W1, OP_SPL_W2, OP_SPL_W3, OP_FULL_W0, OP_FULL_W1,
        OP_X_CUR, OP_PUSH0, OP_PUSH1, OP_UNL0, OP_UNL1,
        OP_WALK, OP_REL_W0, OP_REL_W1, OP_LREAD, OP_LCHK, OP_L_W0, OP_L_W1,
        OP_RREAD, OP_RCHK, OP_R_W0, OP_R_W1
    } t_op;

    typedef struct packed {
        logic             head_v;
        logic             fit;
        logic             nq_none;
        logic             split;
        logic             off_bad;
        logic             at_b;
        logic             used;
        logic             walk_stop;
        logic             b_zero;
        logic             lfree;
        logic             r_in;
        logic             rfree;
        logic [OFF_W-1:0] offset;
    } t_dp_status;

    function automatic logic [IDX_W-1:0] idx_of(input logic [POS_W-1:0] p);
        return p[IDX_W:1];
    endfunction

endpackage

### rtl/btff_datapath.sv
module btff_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  btff_pkg::t_op              i_op,
    input  logic                       i_mode,
    input  logic [btff_pkg::OFF_W-1:0] i_request_bytes,
    input  logic [btff_pkg::OFF_W-1:0] i_release_offset,
    output btff_pkg::t_dp_status       o_st
);
    import btff_pkg::*;

    logic [OFF_W-1:0]  tag_mem  [DEPTH];
    logic [LINK_W-1:0] next_mem [DEPTH];
    logic [LINK_W-1:0] prev_mem [DEPTH];

    logic [OFF_W-1:0]  r_tq;
    logic [LINK_W-1:0] r_nq;
    logic [LINK_W-1:0] r_pq;
    logic [OFF_W-1:0]  r_head;
    logic              r_head_v;
    logic [POS_W-1:0]  r_need;
    logic [OFF_W-1:0]  r_off;
    logic [OFF_W-1:0]  r_cur;
    logic [OFF_W-1:0]  r_size;
    logic [OFF_W-1:0]  r_x;
    logic [POS_W-1:0]  r_e;
    logic [OFF_W-1:0]  r_lb;
    logic [OFF_W-1:0]  r_lmerged;
    logic [OFF_W-1:0]  r_rsize;
    logic [POS_W-1:0]  r_pos;

    logic [IDX_W-1:0]  t_ra, n_ra, p_ra, t_wi, n_wi, p_wi;
    logic              t_we, n_we, p_we;
    logic [OFF_W-1:0]  t_wd;
    logic [LINK_W-1:0] n_wd, p_wd;

    logic [OFF_W-1:0]  size_q, rem, rel_b, lb, lmerged, rmerged;
    logic [POS_W-1:0]  nb, npos, rb, req_ext, need_in, split_end, left_need;

    assign size_q    = {r_tq[OFF_W-1:1], 1'b0};
    assign nb        = {1'b0, r_cur} + TAG2_P + r_need;
    assign rem       = r_size - r_need[OFF_W-1:0] - TAG2_O;
    assign split_end = nb + TAG1_P + {1'b0, rem};
    assign rel_b     = r_off - TAG1_O;
    assign npos      = r_pos + {1'b0, size_q} + TAG2_P;
    assign lb        = r_cur - TAG2_O - size_q;
    assign lmerged   = size_q + r_size + TAG2_O;
    assign left_need = {1'b0, size_q} + TAG2_P;
    assign rb        = r_e + TAG1_P;
    assign rmerged   = r_size + r_rsize + TAG2_O;
    assign req_ext   = {1'b0, i_request_bytes};
    assign need_in   = (req_ext < MIN_N) ? MIN_N
                                         : req_ext + {{OFF_W{1'b0}}, i_request_bytes[0]};

    always_comb begin
        o_st.head_v    = r_head_v;
        o_st.fit       = {1'b0, size_q} >= r_need;
        o_st.nq_none   = r_nq[LINK_W-1];
        o_st.split     = {1'b0, r_size} >= r_need + SPLIT_EXTRA;
        o_st.off_bad   = r_off < TAG1_O;
        o_st.at_b      = r_pos == {1'b0, rel_b};
        o_st.used      = r_tq[0];
        o_st.walk_stop = (r_pos > {1'b0, rel_b}) || (npos > WALK_LIMIT);
        o_st.b_zero    = r_cur == '0;
        o_st.lfree     = !r_tq[0] && ({1'b0, r_cur} >= left_need);
        o_st.r_in      = r_e < RIGHT_LIMIT;
        o_st.rfree     = !r_tq[0];
        o_st.offset    = r_cur + TAG1_O;
    end

    always_comb begin
        t_ra = '0;
        n_ra = '0;
        p_ra = '0;
        t_we = 1'b0;
        t_wi = '0;
        t_wd = '0;
        n_we = 1'b0;
        n_wi = '0;
        n_wd = '0;
        p_we = 1'b0;
        p_wi = '0;
        p_wd = '0;
        unique case (i_op)
            OP_INIT0: begin
                t_we = 1'b1;
                t_wd = INIT_SIZE;
                n_we = 1'b1;
                n_wd = LINK_NONE;
                p_we = 1'b1;
                p_wd = LINK_NONE;
            end
            OP_INIT1: begin
                t_we = 1'b1;
                t_wi = idx_of({1'b0, END_TAG_POS});
                t_wd = INIT_SIZE;
            end
            OP_ACCEPT: begin
                t_ra = i_mode ? '0 : idx_of({1'b0, r_head});
                n_ra = idx_of({1'b0, r_head});
                p_ra = idx_of({1'b0, r_head});
            end
            OP_FIT_STEP: begin
                t_ra = idx_of(r_nq);
                n_ra = idx_of(r_nq);
                p_ra = idx_of(r_nq);
            end
            OP_SPL_W0: begin
                t_we = 1'b1;
                t_wi = idx_of(nb);
                t_wd = rem;
            end
            OP_SPL_W1: begin
                t_we = 1'b1;
                t_wi = idx_of(split_end);
                t_wd = rem;
            end
            OP_SPL_W2: begin
                t_we = 1'b1;
                t_wi = idx_of({1'b0, r_cur} + TAG1_P + r_need);
                t_wd = r_need[OFF_W-1:0] | OFF_W'(1);
            end
            OP_SPL_W3: begin
                t_we = 1'b1;
                t_wi = idx_of({1'b0, r_cur});
                t_wd = r_need[OFF_W-1:0] | OFF_W'(1);
            end
            OP_FULL_W0: begin
                t_we = 1'b1;
                t_wi = idx_of({1'b0, r_cur} + TAG1_P + {1'b0, r_size});
                t_wd = r_size | OFF_W'(1);
            end
            OP_FULL_W1: begin
                t_we = 1'b1;
                t_wi = idx_of({1'b0, r_cur});
                t_wd = r_size | OFF_W'(1);
            end
            OP_PUSH0: begin
                n_we = 1'b1;
                n_wi = idx_of({1'b0, r_x});
                n_wd = r_head_v ? {1'b0, r_head} : LINK_NONE;
                p_we = 1'b1;
                p_wi = idx_of({1'b0, r_x});
                p_wd = LINK_NONE;
            end
            OP_PUSH1: begin
                p_we = r_head_v;
                p_wi = idx_of({1'b0, r_head});
                p_wd = {1'b0, r_x};
            end
            OP_UNL0: begin
                n_ra = idx_of({1'b0, r_x});
                p_ra = idx_of({1'b0, r_x});
            end
            OP_UNL1: begin
                n_we = !r_pq[LINK_W-1];
                n_wi = idx_of(r_pq);
                n_wd = r_nq;
                p_we = !r_nq[LINK_W-1];
                p_wi = idx_of(r_nq);
                p_wd = r_pq;
            end
            OP_WALK: begin
                t_ra = idx_of(npos);
            end
            OP_REL_W0: begin
                t_we = 1'b1;
                t_wi = idx_of({1'b0, r_cur});
                t_wd = r_size;
            end
            OP_REL_W1: begin
                t_we = 1'b1;
                t_wi = idx_of(r_e);
                t_wd = r_size;
            end
            OP_LREAD: begin
                t_ra = idx_of({1'b0, r_cur} - TAG1_P);
            end
            OP_L_W0: begin
                t_we = 1'b1;
                t_wi = idx_of({1'b0, r_lb});
                t_wd = r_lmerged;
            end
            OP_L_W1: begin
                t_we = 1'b1;
                t_wi = idx_of(r_e);
                t_wd = r_lmerged;
            end
            OP_RREAD: begin
                t_ra = idx_of(rb);
            end
            OP_R_W0: begin
                t_we = 1'b1;
                t_wi = idx_of({1'b0, r_cur});
                t_wd = rmerged;
            end
            OP_R_W1: begin
                t_we = 1'b1;
                t_wi = idx_of(r_e + TAG2_P + {1'b0, r_rsize});
                t_wd = rmerged;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            tag_mem[t_wi] <= t_wd;
        end
        if (n_we) begin
            next_mem[n_wi] <= n_wd;
        end
        if (p_we) begin
            prev_mem[p_wi] <= p_wd;
        end
        r_tq <= tag_mem[t_ra];
        r_nq <= next_mem[n_ra];
        r_pq <= prev_mem[p_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
        end else begin
            case (i_op)
                OP_INIT0: begin
                    r_head   <= '0;
                    r_head_v <= 1'b1;
                end
                OP_PUSH1: begin
                    r_head   <= r_x;
                    r_head_v <= 1'b1;
                end
                OP_UNL1: begin
                    if (r_pq[LINK_W-1]) begin
                        if (!r_nq[LINK_W-1]) begin
                            r_head <= r_nq[OFF_W-1:0];
                        end else begin
                            r_head_v <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                r_need <= need_in;
                r_off  <= i_release_offset;
                r_cur  <= r_head;
                r_pos  <= '0;
            end
            OP_FIT_STEP: begin
                if ({1'b0, size_q} >= r_need) begin
                    r_size <= size_q;
                end else begin
                    r_cur <= r_nq[OFF_W-1:0];
                end
            end
            OP_SPL_W3: r_x <= nb[OFF_W-1:0];
            OP_FULL_W1, OP_X_CUR, OP_REL_W1: r_x <= r_cur;
            OP_WALK: begin
                r_pos  <= npos;
                r_cur  <= r_pos[OFF_W-1:0];
                r_size <= size_q;
            end
            OP_REL_W0: r_e <= {1'b0, r_cur} + TAG1_P + {1'b0, r_size};
            OP_LCHK: begin
                r_lb      <= lb;
                r_lmerged <= lmerged;
            end
            OP_L_W1: begin
                r_x    <= r_cur;
                r_cur  <= r_lb;
                r_size <= r_lmerged;
            end
            OP_RCHK: begin
                r_rsize <= size_q;
                r_x     <= rb[OFF_W-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/btff_controller.sv
module btff_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_mode,
    input  logic                       i_stall,
    input  btff_pkg::t_dp_status       i_st,
    output btff_pkg::t_op              o_op,
    output logic                       o_stall,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [btff_pkg::OFF_W-1:0] o_payload_offset
);
    import btff_pkg::*;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_A_STEP, S_A_TAKE, S_SPL1, S_SPL2, S_SPL3,
        S_FULL1, S_A_UNX, S_PUSH0, S_PUSH1, S_UNL0, S_UNL1,
        S_R_WALK, S_R_W0, S_R_W1, S_R_LEFT, S_R_LCHK, S_R_LW0, S_R_LW1,
        S_R_RIGHT, S_R_RCHK, S_R_RW0, S_R_RW1, S_FIN
    } t_state;

    t_state           r_state, n_state, r_ret, n_ret;
    logic [1:0]       r_res_status, n_res_status;
    logic             r_res_off, n_res_off;
    logic             r_valid;
    logic [1:0]       r_status;
    logic [OFF_W-1:0] r_offset;
    logic             load_out;

    assign o_stall          = r_state != S_IDLE;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_payload_offset = r_offset;
    assign load_out         = (r_state == S_FIN) && (!r_valid || !i_stall);

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        o_op         = OP_NOP;
        unique case (r_state)
            S_INIT0: begin
                o_op    = OP_INIT0;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                o_op    = OP_INIT1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_op = OP_ACCEPT;
                    if (i_mode) begin
                        n_state = S_R_WALK;
                    end else if (!i_st.head_v) begin
                        n_state      = S_FIN;
                        n_res_status = ST_NOFIT;
                        n_res_off    = 1'b0;
                    end else begin
                        n_state = S_A_STEP;
                    end
                end
            end
            S_A_STEP: begin
                o_op = OP_FIT_STEP;
                if (i_st.fit) begin
                    n_state = S_A_TAKE;
                end else if (i_st.nq_none) begin
                    n_state      = S_FIN;
                    n_res_status = ST_NOFIT;
                    n_res_off    = 1'b0;
                end
            end
            S_A_TAKE: begin
                if (i_st.split) begin
                    o_op    = OP_SPL_W0;
                    n_state = S_SPL1;
                end else begin
                    o_op    = OP_FULL_W0;
                    n_state = S_FULL1;
                end
            end
            S_SPL1: begin
                o_op    = OP_SPL_W1;
                n_state = S_SPL2;
            end
            S_SPL2: begin
                o_op    = OP_SPL_W2;
                n_state = S_SPL3;
            end
            S_SPL3: begin
                o_op    = OP_SPL_W3;
                n_state = S_PUSH0;
                n_ret   = S_A_UNX;
            end
            S_A_UNX: begin
                o_op         = OP_X_CUR;
                n_state      = S_UNL0;
                n_ret        = S_FIN;
                n_res_status = ST_DONE;
                n_res_off    = 1'b1;
            end
            S_FULL1: begin
                o_op         = OP_FULL_W1;
                n_state      = S_UNL0;
                n_ret        = S_FIN;
                n_res_status = ST_DONE;
                n_res_off    = 1'b1;
            end
            S_PUSH0: begin
                o_op    = OP_PUSH0;
                n_state = S_PUSH1;
            end
            S_PUSH1: begin
                o_op    = OP_PUSH1;
                n_state = r_ret;
            end
            S_UNL0: begin
                o_op    = OP_UNL0;
                n_state = S_UNL1;
            end
            S_UNL1: begin
                o_op    = OP_UNL1;
                n_state = r_ret;
            end
            S_R_WALK: begin
                o_op = OP_WALK;
                if (i_st.off_bad || (i_st.at_b && !i_st.used)
                        || (!i_st.at_b && i_st.walk_stop)) begin
                    n_state      = S_FIN;
                    n_res_status = ST_IGNORED;
                    n_res_off    = 1'b0;
                end else if (i_st.at_b) begin
                    n_state = S_R_W0;
                end
            end
            S_R_W0: begin
                o_op    = OP_REL_W0;
                n_state = S_R_W1;
            end
            S_R_W1: begin
                o_op    = OP_REL_W1;
                n_state = S_PUSH0;
                n_ret   = S_R_LEFT;
            end
            S_R_LEFT: begin
                if (i_st.b_zero) begin
                    n_state = S_R_RIGHT;
                end else begin
                    o_op    = OP_LREAD;
                    n_state = S_R_LCHK;
                end
            end
            S_R_LCHK: begin
                o_op    = OP_LCHK;
                n_state = i_st.lfree ? S_R_LW0 : S_R_RIGHT;
            end
            S_R_LW0: begin
                o_op    = OP_L_W0;
                n_state = S_R_LW1;
            end
            S_R_LW1: begin
                o_op    = OP_L_W1;
                n_state = S_UNL0;
                n_ret   = S_R_RIGHT;
            end
            S_R_RIGHT: begin
                if (i_st.r_in) begin
                    o_op    = OP_RREAD;
                    n_state = S_R_RCHK;
                end else begin
                    n_state      = S_FIN;
                    n_res_status = ST_DONE;
                    n_res_off    = 1'b0;
                end
            end
            S_R_RCHK: begin
                o_op = OP_RCHK;
                if (i_st.rfree) begin
                    n_state = S_UNL0;
                    n_ret   = S_R_RW0;
                end else begin
                    n_state      = S_FIN;
                    n_res_status = ST_DONE;
                    n_res_off    = 1'b0;
                end
            end
            S_R_RW0: begin
                o_op    = OP_R_W0;
                n_state = S_R_RW1;
            end
            S_R_RW1: begin
                o_op         = OP_R_W1;
                n_state      = S_FIN;
                n_res_status = ST_DONE;
                n_res_off    = 1'b0;
            end
            S_FIN: begin
                if (!r_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT0;
            r_ret        <= S_IDLE;
            r_res_status <= ST_DONE;
            r_res_off    <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_res_status <= n_res_status;
            r_res_off    <= n_res_off;
            if (load_out) begin
                r_valid  <= 1'b1;
                r_status <= r_res_status;
                r_offset <= r_res_off ? i_st.offset : '0;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/boundary_tag_first_fit_allocator.sv
// Allocate: walks the free list from its head to the first block that fits, and takes it
// whole or splits it and pushes the remainder; a request that fits nowhere answers NOFIT.
// Release: walks the blocks from offset 0 to the released one, frees it, and merges it
// with each free neighbor; a release that does not land on a used block is ignored.
// One item is worked at a time, and the next beat can be accepted in the same cycle that a result is presented.
// After reset, the states S_INIT0 and S_INIT1 write the tags of the initial free block, input stalled.
module boundary_tag_first_fit_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_mode,
    input  logic [btff_pkg::OFF_W-1:0] i_request_bytes,
    input  logic [btff_pkg::OFF_W-1:0] i_release_offset,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [btff_pkg::OFF_W-1:0] o_payload_offset
);
    import btff_pkg::*;

    t_op        op;
    t_dp_status st;

    btff_controller u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_mode           (i_mode),
        .i_stall          (i_stall),
        .i_st             (st),
        .o_op             (op),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset)
    );

    btff_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_mode           (i_mode),
        .i_request_bytes  (i_request_bytes),
        .i_release_offset (i_release_offset),
        .o_st             (st)
    );

endmodule
